>>> sv/flow_vector_color_coder_core_macros.svh
// Assertion macros for the flow vector colour coder
`ifndef FLOW_VECTOR_COLOR_CODER_CORE_MACROS_SVH
`define FLOW_VECTOR_COLOR_CODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FVCC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FVCC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

>>> sv/fvcc_pkg.sv
// Types, constants and tables for the flow vector colour coder
`default_nettype none
package fvcc_pkg;

	localparam int FLOW_BITS     = 20;
	localparam int PRESCALE_BITS = 20;
	localparam int CORDIC_W      = FLOW_BITS + PRESCALE_BITS + 3;
	localparam int MAG_W         = CORDIC_W - 1 - PRESCALE_BITS;
	localparam int INV_W         = 24;
	localparam int WHEEL_ENTRIES = 55;
	localparam int SEG_RY = 15;
	localparam int SEG_YG = 6;
	localparam int SEG_GC = 4;
	localparam int SEG_CB = 11;
	localparam int SEG_BM = 13;
	localparam int SEG_MR = 6;
	localparam logic [29:0] INV_GAIN = 30'd652032874;
	localparam logic [INV_W-1:0] INV_RESET = 24'd262144;

	typedef struct packed {
		logic signed [FLOW_BITS-1:0] flow_u;
		logic signed [FLOW_BITS-1:0] flow_v;
		logic                        unknown_flow;
	} flow_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_out_t;

	typedef struct packed {
		logic valid;
		logic unknown;
	} lane_ctl_t;

	typedef logic [23:0] wheel_t [WHEEL_ENTRIES];

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2F9;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

	function automatic wheel_t build_wheel();
		wheel_t w;
		int r, g, b, i;
		for (int k = 0; k < WHEEL_ENTRIES; k++) begin
			if (k < SEG_RY) begin
				i = k; r = 255; g = 255 * i / SEG_RY; b = 0;
			end else if (k < SEG_RY + SEG_YG) begin
				i = k - SEG_RY; r = 255 - 255 * i / SEG_YG; g = 255; b = 0;
			end else if (k < SEG_RY + SEG_YG + SEG_GC) begin
				i = k - SEG_RY - SEG_YG; r = 0; g = 255; b = 255 * i / SEG_GC;
			end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
				i = k - SEG_RY - SEG_YG - SEG_GC; r = 0; g = 255 - 255 * i / SEG_CB; b = 255;
			end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM) begin
				i = k - SEG_RY - SEG_YG - SEG_GC - SEG_CB; r = 255 * i / SEG_BM; g = 0; b = 255;
			end else begin
				i = k - SEG_RY - SEG_YG - SEG_GC - SEG_CB - SEG_BM;
				if (i >= SEG_MR)
					i = SEG_MR - 1;
				r = 255; g = 0; b = 255 - 255 * i / SEG_MR;
			end
			w[k] = {r[7:0], g[7:0], b[7:0]};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

>>> sv/fvcc_cordic_cell.sv
// One vectoring CORDIC cell: a micro-rotation and its register
`default_nettype none
module fvcc_cordic_cell
	import fvcc_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire lane_ctl_t                  ctl_in,
	input  wire logic signed [CORDIC_W-1:0] x_in,
	input  wire logic signed [CORDIC_W-1:0] y_in,
	input  wire logic [31:0]                z_in,
	output lane_ctl_t                       ctl_out,
	output logic signed [CORDIC_W-1:0]      x_out,
	output logic signed [CORDIC_W-1:0]      y_out,
	output logic [31:0]                     z_out
);

	localparam logic [31:0] ATAN = atan_turn(5'(STAGE));

	logic signed [CORDIC_W-1:0] x_n, y_n;
	logic [31:0] z_n;
	lane_ctl_t ctl_q;
	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic [31:0] z_q;

	always_comb begin
		if (y_in > 0) begin
			x_n = x_in + (y_in >>> STAGE);
			y_n = y_in - (x_in >>> STAGE);
			z_n = z_in + ATAN;
		end else begin
			x_n = x_in - (y_in >>> STAGE);
			y_n = y_in + (x_in >>> STAGE);
			z_n = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign z_out   = z_q;

endmodule
`default_nettype wire

>>> sv/fvcc_colour_path.sv
// Radius scaling, wheel lookup, interpolation and saturation stages
`default_nettype none
module fvcc_colour_path
	import fvcc_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire lane_ctl_t                  ctl_in,
	input  wire logic signed [CORDIC_W-1:0] x_in,
	input  wire logic [31:0]                z_in,
	input  wire logic [INV_W-1:0]           inv,
	output logic                            valid,
	output rgb_out_t                        rgb
);

	localparam wheel_t WHEEL = build_wheel();
	localparam logic [23:0] FULL = 24'd16711680;
	localparam logic [5:0] LAST = 6'(WHEEL_ENTRIES - 1);
	localparam logic [5:0] SPAN = 6'(WHEEL_ENTRIES - 1);

	lane_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic [MAG_W-1:0] mag;
	logic [MAG_W+29:0] prod_s1;
	logic [37:0] t_s1;
	logic [MAG_W+INV_W-1:0] rad_s2;
	logic [5:0] k0_s2, k1_s2;
	logic [15:0] f_s2, f_s3;
	logic le_s3, le_s4, le_s5;
	logic [24:0] rad_s3, rad_s4, rad_s5;
	logic [23:0] c0_s3, c1_s3;
	logic [23:0] c_s4 [3];
	logic [48:0] p_s5 [3];
	logic [7:0] o_s6 [3];
	logic [23:0] c_n [3];
	logic [48:0] p_n [3];
	logic [7:0] o_n [3];
	logic [31:0] phase;
	logic [5:0] k0;

	assign mag   = x_in[CORDIC_W-1] ? '0 : x_in[CORDIC_W-2:PRESCALE_BITS];
	assign phase = z_in + 32'h80000000;
	assign k0    = t_s1[37:32];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			c_n[ch] = 24'((25'(c0_s3[23-8*ch -: 8]) * (25'(17'h10000) - 25'(f_s3)))
				+ (25'(c1_s3[23-8*ch -: 8]) * 25'(f_s3)));
			if (le_s4)
				p_n[ch] = 49'(FULL - c_s4[ch]) * 49'(rad_s4);
			else
				p_n[ch] = 49'(c_s4[ch]) * 49'd3;
			if (le_s5)
				o_n[ch] = 8'((FULL - 24'(p_s5[ch] >> 24)) >> 16);
			else
				o_n[ch] = 8'(p_s5[ch] >> 18);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (MAG_W+30)'(mag) * (MAG_W+30)'(INV_GAIN);
			t_s1    <= 38'(phase) * 38'(SPAN);
			rad_s2  <= (MAG_W+INV_W)'(prod_s1[MAG_W+29:30]) * (MAG_W+INV_W)'(inv);
			k0_s2   <= k0;
			k1_s2   <= (k0 >= LAST) ? 6'd0 : k0 + 6'd1;
			f_s2    <= t_s1[31:16];
			le_s3   <= rad_s2 <= (MAG_W+INV_W)'(25'h1000000);
			rad_s3  <= rad_s2[24:0];
			c0_s3   <= WHEEL[k0_s2];
			c1_s3   <= WHEEL[k1_s2];
			f_s3    <= f_s2;
			le_s4   <= le_s3;
			rad_s4  <= rad_s3;
			le_s5   <= le_s4;
			rad_s5  <= rad_s4;
			for (int ch = 0; ch < 3; ch++) begin
				c_s4[ch] <= c_n[ch];
				p_s5[ch] <= p_n[ch];
				o_s6[ch] <= ctl_s5.unknown ? 8'd0 : o_n[ch];
			end
		end
	end

	assign valid     = ctl_s6.valid;
	assign rgb.red   = o_s6[0];
	assign rgb.green = o_s6[1];
	assign rgb.blue  = o_s6[2];

endmodule
`default_nettype wire

>>> sv/flow_vector_color_coder_core.sv
// Top level of the flow vector colour coder
//   channel | signals                   | payload
//   vec     | vec_valid / vec_ready     | flow_in_t: flow_u, flow_v, unknown_flow
//   rgb     | rgb_valid / rgb_ready     | rgb_out_t: red, green, blue
//   cfg     | cfg_valid / cfg_ready     | cfg_data: inverse_max_radius, 24 bits
// One vector per cycle while rgb is not stalled; the path is an entry register, one
// cell per CORDIC stage and six colour stages.
// A stalled rgb transaction freezes the whole chain, so vec_ready follows rgb_ready
// while a result is held. cfg is always ready; reset loads inverse_max_radius = 1.0.
`default_nettype none
module flow_vector_color_coder_core
	import fvcc_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vec_valid,
	output logic                  vec_ready,
	input  wire flow_in_t         vec,
	output logic                  rgb_valid,
	input  wire logic             rgb_ready,
	output rgb_out_t              rgb,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [INV_W-1:0] cfg_data
);

	logic en;
	logic [INV_W-1:0] inv_q;
	lane_ctl_t ctl_s1;
	logic signed [CORDIC_W-1:0] x_s1, y_s1;
	logic [31:0] z_s1;
	logic signed [CORDIC_W-1:0] u_ext, v_ext;

	lane_ctl_t ctl_c [CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] x_c [CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] y_c [CORDIC_STAGES+1];
	logic [31:0] z_c [CORDIC_STAGES+1];

	assign en        = !rgb_valid || rgb_ready;
	assign vec_ready = en;
	assign cfg_ready = 1'b1;
	assign u_ext     = CORDIC_W'(vec.flow_u) <<< PRESCALE_BITS;
	assign v_ext     = CORDIC_W'(vec.flow_v) <<< PRESCALE_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: vec_valid, unknown: vec.unknown_flow};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (u_ext > 0) begin
				x_s1 <= u_ext;
				y_s1 <= v_ext;
				z_s1 <= 32'h80000000;
			end else begin
				x_s1 <= -u_ext;
				y_s1 <= -v_ext;
				z_s1 <= 32'h0;
			end
		end
	end

	assign ctl_c[0] = ctl_s1;
	assign x_c[0]   = x_s1;
	assign y_c[0]   = y_s1;
	assign z_c[0]   = z_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		fvcc_cordic_cell #(.STAGE(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_c[g]),
			.x_in   (x_c[g]),
			.y_in   (y_c[g]),
			.z_in   (z_c[g]),
			.ctl_out(ctl_c[g+1]),
			.x_out  (x_c[g+1]),
			.y_out  (y_c[g+1]),
			.z_out  (z_c[g+1])
		);
	end

	fvcc_colour_path u_colour (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_c[CORDIC_STAGES]),
		.x_in   (x_c[CORDIC_STAGES]),
		.z_in   (z_c[CORDIC_STAGES]),
		.inv    (inv_q),
		.valid  (rgb_valid),
		.rgb    (rgb)
	);

	// y of the last cell has no consumer
	logic unused_y;
	assign unused_y = ^y_c[CORDIC_STAGES];

endmodule
`default_nettype wire

>>> sv/fvcc_checker.sv
// Port-level checker for the flow vector colour coder, bound to the top level
`default_nettype none
`include "flow_vector_color_coder_core_macros.svh"
module fvcc_checker
	import fvcc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             vec_valid,
	input wire logic             vec_ready,
	input wire flow_in_t         vec,
	input wire logic             rgb_valid,
	input wire logic             rgb_ready,
	input wire rgb_out_t         rgb,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [INV_W-1:0] cfg_data
);

	`FVCC_ASSERT_NEXT(a_rgb_hold, rgb_valid && !rgb_ready, rgb_valid, "rgb valid dropped")
	`FVCC_ASSERT_NEXT(a_rgb_stable, rgb_valid && !rgb_ready, $stable(rgb), "rgb changed")
	`FVCC_ASSERT_NOW(a_vec_free, !rgb_valid, vec_ready, "vec stalled with empty output")
	`FVCC_ASSERT_NOW(a_vec_stall, rgb_valid && !rgb_ready, !vec_ready, "vec taken in stall")
	`FVCC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg not ready")

endmodule

bind flow_vector_color_coder_core fvcc_checker u_fvcc_checker (.*);
`default_nettype wire

>>> sim/tb_flow_vector_color_coder_core.sv
// Self-checking testbench for the flow vector colour coder: directed table, then random vectors
`default_nettype none
module tb_flow_vector_color_coder_core;
	import fvcc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES    = 16;
	localparam int LATENCY   = STAGES + 7;
	localparam int WDOG_MAX  = 4000;
	localparam int N_RANDOM  = 750;

	logic clk, arst_n;
	logic vec_valid, vec_ready;
	flow_in_t vec;
	logic rgb_valid, rgb_ready;
	rgb_out_t rgb;
	logic cfg_valid, cfg_ready;
	logic [INV_W-1:0] cfg_data;

	flow_vector_color_coder_core #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
		.rgb_valid(rgb_valid), .rgb_ready(rgb_ready), .rgb(rgb),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rgb_out_t colour_q [$];
	logic [INV_W-1:0] inv_radius;
	wheel_t hue_wheel;
	int mismatches, results_seen, vectors_sent, idle_cycles;
	bit rx_idle_on, rx_hold, timed_out;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] fshr(input logic signed [63:0] a, input int s);
		return a >>> s;
	endfunction

	function automatic rgb_out_t colour_of(input flow_in_t f, input logic [INV_W-1:0] inv);
		logic signed [63:0] x, y, nx;
		logic [31:0] z, phase, k0, k1, fr;
		logic [63:0] mag, rad, t, c, full, o;
		logic [7:0] ch [3];
		rgb_out_t r;
		if (f.unknown_flow) begin
			r = '0;
			return r;
		end
		x = -(64'(signed'(f.flow_u)) <<< PRESCALE_BITS);
		y = -(64'(signed'(f.flow_v)) <<< PRESCALE_BITS);
		z = 32'h0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h80000000;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y > 0) begin
				nx = x + fshr(y, i); y = y - fshr(x, i); z = z + atan_turn(i[4:0]);
			end else begin
				nx = x - fshr(y, i); y = y + fshr(x, i); z = z - atan_turn(i[4:0]);
			end
			x = nx;
		end
		if (x < 0) x = 0;
		mag = 64'(x) >> PRESCALE_BITS;
		mag = (mag * 64'(INV_GAIN)) >> 30;
		rad = mag * 64'(inv);
		phase = z + 32'h80000000;
		t = 64'(phase) * 64'(WHEEL_ENTRIES - 1);
		k0 = t[63:32];
		fr = {16'h0, t[31:16]};
		k1 = (k0 + 1 >= WHEEL_ENTRIES) ? 0 : k0 + 1;
		full = 64'd255 << 16;
		for (int n = 0; n < 3; n++) begin
			c = 64'(hue_wheel[k0][23-8*n -: 8]) * (64'd65536 - fr)
				+ 64'(hue_wheel[k1][23-8*n -: 8]) * fr;
			if (rad <= (64'd1 << 24))
				o = (full - (((full - c) * rad) >> 24)) >> 16;
			else
				o = (3 * c) >> 18;
			ch[n] = o[7:0];
		end
		r.red = ch[0]; r.green = ch[1]; r.blue = ch[2];
		return r;
	endfunction

	always @(posedge clk) begin
		if (vec_valid && vec_ready) begin
			colour_q.push_back(colour_of(vec, inv_radius));
			vectors_sent++;
		end
		if (cfg_valid && cfg_ready)
			inv_radius <= cfg_data;
		if (rgb_valid && rgb_ready) begin
			results_seen++;
			if (colour_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected colour %h", rgb);
			end else begin
				rgb_out_t e;
				e = colour_q.pop_front();
				if (e.red !== rgb.red || e.green !== rgb.green || e.blue !== rgb.blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("colour mismatch exp %h %h %h got %h %h %h",
							e.red, e.green, e.blue, rgb.red, rgb.green, rgb.blue);
				end
			end
		end
		if ((vec_valid && vec_ready) || (rgb_valid && rgb_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		rgb_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				rgb_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				rx_hold = 1'b0;
			end
			if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				rgb_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rgb_ready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles > WDOG_MAX) begin
				timed_out = 1'b1;
				$display("FAIL flow_vector_color_coder_core");
				$finish;
			end
		end
	end

	task automatic send_vector(input flow_in_t f, input bit gaps);
		int n;
		if (gaps && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 12);
			vec_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= f;
		@(posedge clk);
		while (!vec_ready) @(posedge clk);
	endtask

	task automatic write_radius(input logic [INV_W-1:0] val);
		vec_valid <= 1'b0;
		while (colour_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic flow_in_t make_vec(input int u, input int v, input bit unk);
		flow_in_t f;
		f.flow_u = u[FLOW_BITS-1:0];
		f.flow_v = v[FLOW_BITS-1:0];
		f.unknown_flow = unk;
		return f;
	endfunction

	function automatic flow_in_t rand_vec(input int span);
		int u, v;
		u = $urandom_range(0, 2 * span) - span;
		v = $urandom_range(0, 2 * span) - span;
		return make_vec(u, v, $urandom_range(0, 15) == 0);
	endfunction

	typedef struct {
		int u;
		int v;
		bit unk;
		bit known;
		rgb_out_t colour;
	} vec_row_t;

	vec_row_t directed [] = '{
		'{0, 0, 1'b1, 1'b1, 24'h000000},
		'{524287, -524288, 1'b1, 1'b1, 24'h000000},
		'{0, 0, 1'b0, 1'b1, 24'hFFFFFF},
		'{524287, 0, 1'b0, 1'b0, 24'h0},
		'{-524288, 0, 1'b0, 1'b0, 24'h0},
		'{0, 524287, 1'b0, 1'b0, 24'h0},
		'{0, -524288, 1'b0, 1'b0, 24'h0},
		'{524287, 524287, 1'b0, 1'b0, 24'h0},
		'{-524288, -524288, 1'b0, 1'b0, 24'h0},
		'{64, 0, 1'b0, 1'b0, 24'h0},
		'{-64, 0, 1'b0, 1'b0, 24'h0},
		'{0, 64, 1'b0, 1'b0, 24'h0},
		'{0, -64, 1'b0, 1'b0, 24'h0},
		'{32, -1, 1'b0, 1'b0, 24'h0},
		'{32, 1, 1'b0, 1'b0, 24'h0},
		'{1, 0, 1'b0, 1'b0, 24'h0},
		'{-1, -1, 1'b0, 1'b0, 24'h0},
		'{-349525, 174762, 1'b0, 1'b0, 24'h0},
		'{-699050, 0, 1'b0, 1'b0, 24'h0}
	};

	initial begin
		flow_in_t f;
		rgb_out_t got_known;
		int span;
		hue_wheel = build_wheel();
		inv_radius = INV_RESET;
		mismatches = 0; results_seen = 0; vectors_sent = 0; idle_cycles = 0;
		rx_idle_on = 1'b0; rx_hold = 1'b0; timed_out = 1'b0; hold_cycles = 0;
		vec_valid = 1'b0; vec = '0; cfg_valid = 1'b0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			f = make_vec(directed[i].u, directed[i].v, directed[i].unk);
			if (directed[i].known) begin
				got_known = colour_of(f, inv_radius);
				if (got_known !== directed[i].colour) begin
					mismatches++;
					$display("table row %0d exp %h got %h", i, directed[i].colour, got_known);
				end
			end
			send_vector(f, 1'b0);
		end
		write_radius('0);
		send_vector(make_vec(1000, -2000, 1'b0), 1'b0);
		write_radius(24'hFFFFFF);
		send_vector(make_vec(1, 0, 1'b0), 1'b0);
		send_vector(make_vec(-524288, 524287, 1'b0), 1'b0);

		rx_idle_on = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			case (i)
				0:   write_radius(24'd1);
				150: write_radius(24'd4096);
				300: write_radius(INV_RESET);
				450: write_radius(24'(24'd100 + $urandom_range(0, 16000)));
				600: write_radius(24'($urandom_range(1, 24'hFFFFFF)));
				default: ;
			endcase
			if (i == 200) begin
				hold_cycles = 200;
				rx_hold = 1'b1;
			end
			if (i >= 680) rx_idle_on = 1'b0;
			case ($urandom_range(0, 3))
				0: span = 524287;
				1: span = 8192;
				2: span = 300;
				default: span = 64 * (1 + $urandom_range(0, 20));
			endcase
			if (i % 60 == 5)
				f = make_vec(-524288 + $urandom_range(0, 1), $urandom_range(0, 1)*524287, 1'b0);
			else
				f = rand_vec(span);
			send_vector(f, i < 680);
		end
		vec_valid <= 1'b0;

		while (colour_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Covered %0d vectors and %0d colours over several radius settings.",
			vectors_sent, results_seen);
		if (mismatches == 0 && !timed_out)
			$display("PASS flow_vector_color_coder_core");
		else
			$display("FAIL flow_vector_color_coder_core");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/fvcc_pkg.sv
sv/fvcc_cordic_cell.sv
sv/fvcc_colour_path.sv
sv/flow_vector_color_coder_core.sv
sv/fvcc_checker.sv
sim/tb_flow_vector_color_coder_core.sv
